// ----- rtl/core/swbpe_pkg.sv -----
package swbpe_pkg;

   // widest window the design supports, sets the fixed widths below
   localparam int MAX_DEPTH = 64;
   localparam int MAX_CNT_W = 7;
   localparam int MAX_PTR_W = 6;

   localparam int BLK_W     = 64;
   localparam int SIZE_W    = 5;
   localparam int SHIFT_W   = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SHIFT = 1'b1;

   localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RESET = 6'd16;

   // one classified access handed from front to back
   typedef struct packed {
      logic [BLK_W-1:0]     blk;
      logic [MAX_CNT_W-1:0] pairs;
      logic [MAX_PTR_W-1:0] base;
      logic [MAX_PTR_W-1:0] wr_addr;
      logic                 push;
   } swbpe_item_type;

endpackage

// ----- rtl/core/sliding_window_block_pair_emitter.sv -----
// path: each pair passes the queue entry, the window read register and the result buffer
// throughput: each access gives one pair per entry in the window (at most WINDOW_DEPTH),
//   set by the single read port of the window memory, one pair per cycle while rsp_stall is low
// reset: window empty, window_size 0, block_shift 16; window memory contents undefined,
//   no clearing pass, the block takes beats from the first cycle after reset
module sliding_window_block_pair_emitter
   import swbpe_pkg::*;
#(
   parameter int WINDOW_DEPTH = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BLK_W-1:0]     req_byte_offset,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BLK_W-1:0]     rsp_earlier_block,
   output logic [BLK_W-1:0]     rsp_current_block,
   output logic                 rsp_last_pair
);

   logic           fq_push, fq_full;
   swbpe_item_type fq_item;
   logic           bq_valid, bq_pop;
   swbpe_item_type bq_item;

   // front: config, block number, window bookkeeping
   swbpe_front #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_byte_offset (req_byte_offset),
      .req_stall       (req_stall),
      .q_push          (fq_push),
      .q_item          (fq_item),
      .q_full          (fq_full)
   );

   // decoupling queue
   swbpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_item (fq_item),
      .full      (fq_full),
      .pop_valid (bq_valid),
      .pop_item  (bq_item),
      .pop       (bq_pop)
   );

   // back: window memory walk and result buffer
   swbpe_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (bq_valid),
      .q_item            (bq_item),
      .q_pop             (bq_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_earlier_block (rsp_earlier_block),
      .rsp_current_block (rsp_current_block),
      .rsp_last_pair     (rsp_last_pair)
   );

endmodule

// ----- rtl/core/swbpe_queue.sv -----
module swbpe_queue
   import swbpe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  swbpe_item_type push_item,
   output logic           full,
   output logic           pop_valid,
   output swbpe_item_type pop_item,
   input  logic           pop
);

   swbpe_item_type ents_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     occ_ff, occ_in;
   logic           do_push, do_pop;

   assign full      = (occ_ff == 2'd2);
   assign pop_valid = (occ_ff != 2'd0);
   assign pop_item  = ents_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      occ_in    = occ_ff;
      if (do_push && !do_pop) begin
         occ_in = occ_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         occ_in = occ_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         occ_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         ents_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/swbpe_front.sv -----
module swbpe_front
   import swbpe_pkg::*;
#(
   parameter int WINDOW_DEPTH = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  logic                 req_valid,
   input  logic [BLK_W-1:0]     req_byte_offset,
   output logic                 req_stall,
   output logic                 q_push,
   output swbpe_item_type       q_item,
   input  logic                 q_full
);

   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam logic [MAX_CNT_W-1:0] DEPTH_C = MAX_CNT_W'(WINDOW_DEPTH);
   localparam logic [PTR_W-1:0]     LAST_PTR = PTR_W'(WINDOW_DEPTH - 1);

   logic [SIZE_W-1:0]    window_size_ff, window_size_in;
   logic [SHIFT_W-1:0]   block_shift_ff, block_shift_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic                 accept;
   logic [MAX_CNT_W-1:0] size_ext, limit, cnt_ext, cnt_inc, new_cnt;
   logic [PTR_W-1:0]     head_dec;
   logic                 push_blk;

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;

   // configuration writes
   always_comb begin
      window_size_in = window_size_ff;
      block_shift_in = block_shift_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_WINDOW_SIZE: window_size_in = csr_wdata[SIZE_W-1:0];
            CSR_BLOCK_SHIFT: block_shift_in = csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // window fill after this access
   always_comb begin
      size_ext = MAX_CNT_W'(window_size_ff);
      limit    = (size_ext > DEPTH_C) ? DEPTH_C : size_ext;
      cnt_ext  = MAX_CNT_W'(count_ff);
      cnt_inc  = cnt_ext + MAX_CNT_W'(1);
      new_cnt  = (cnt_inc > limit) ? cnt_ext : cnt_inc;
      push_blk = (new_cnt != '0);
      head_dec = (head_ff == '0) ? LAST_PTR : head_ff - PTR_W'(1);
   end

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      if (accept) begin
         count_in = new_cnt[CNT_W-1:0];
         if (push_blk) begin
            head_in = head_dec;
         end
      end
   end

   // classified beat for the back end
   always_comb begin
      q_push         = accept;
      q_item.blk     = req_byte_offset >> block_shift_ff;
      q_item.pairs   = cnt_ext;
      q_item.base    = MAX_PTR_W'(head_ff);
      q_item.wr_addr = MAX_PTR_W'(head_dec);
      q_item.push    = push_blk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= '0;
         block_shift_ff <= BLOCK_SHIFT_RESET;
         count_ff       <= '0;
         head_ff        <= '0;
      end else begin
         window_size_ff <= window_size_in;
         block_shift_ff <= block_shift_in;
         count_ff       <= count_in;
         head_ff        <= head_in;
      end
   end

endmodule

// ----- rtl/core/swbpe_back.sv -----
module swbpe_back
   import swbpe_pkg::*;
#(
   parameter int WINDOW_DEPTH = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  swbpe_item_type   q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [BLK_W-1:0] rsp_earlier_block,
   output logic [BLK_W-1:0] rsp_current_block,
   output logic             rsp_last_pair
);

   localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam logic [PTR_W:0] DEPTH_C = (PTR_W + 1)'(WINDOW_DEPTH);

   typedef struct packed {
      logic [BLK_W-1:0] earlier;
      logic [BLK_W-1:0] current;
      logic             last;
   } pair_type;

   logic [BLK_W-1:0]     mem [WINDOW_DEPTH];
   logic [MAX_CNT_W-1:0] idx_ff, idx_in;
   logic [BLK_W-1:0]     rd_data_ff;
   logic [BLK_W-1:0]     rd_cur_ff;
   logic                 rd_last_ff;
   logic                 inflight_ff, inflight_in;
   pair_type             out_ff [2];
   logic                 out_wr_ff, out_rd_ff;
   logic [1:0]           out_occ_ff, out_occ_in;
   logic [1:0]           used;
   logic                 out_pop, room, issue, last_rd, wr_en, zero_pairs;
   logic [PTR_W:0]       addr_sum;
   logic [PTR_W-1:0]     rd_addr, wr_addr;

   // output side
   assign rsp_valid         = (out_occ_ff != 2'd0);
   assign out_pop           = rsp_valid && !rsp_stall;
   assign rsp_earlier_block = out_ff[out_rd_ff].earlier;
   assign rsp_current_block = out_ff[out_rd_ff].current;
   assign rsp_last_pair     = out_ff[out_rd_ff].last;

   // read credit: results buffered plus the one in flight
   assign used = out_occ_ff + 2'(inflight_ff);
   assign room = (used < 2'd2) || out_pop;

   // ring address of the window entry being read
   always_comb begin
      addr_sum = (PTR_W + 1)'(q_item.base[PTR_W-1:0]) + (PTR_W + 1)'(idx_ff[PTR_W-1:0]);
      if (addr_sum >= DEPTH_C) begin
         addr_sum = addr_sum - DEPTH_C;
      end
      rd_addr = addr_sum[PTR_W-1:0];
      wr_addr = q_item.wr_addr[PTR_W-1:0];
   end

   // sequencing over the pairs of one access
   always_comb begin
      zero_pairs  = (q_item.pairs == '0);
      issue       = q_valid && !zero_pairs && room;
      last_rd     = (idx_ff == q_item.pairs - MAX_CNT_W'(1));
      q_pop       = q_valid && (zero_pairs || (issue && last_rd));
      wr_en       = q_pop && q_item.push;
      inflight_in = issue;
      idx_in      = idx_ff;
      if (issue) begin
         idx_in = last_rd ? '0 : idx_ff + MAX_CNT_W'(1);
      end
   end

   always_comb begin
      out_occ_in = out_occ_ff;
      if (inflight_ff && !out_pop) begin
         out_occ_in = out_occ_ff + 2'd1;
      end else if (out_pop && !inflight_ff) begin
         out_occ_in = out_occ_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         inflight_ff <= 1'b0;
         out_wr_ff   <= 1'b0;
         out_rd_ff   <= 1'b0;
         out_occ_ff  <= 2'd0;
      end else begin
         idx_ff      <= idx_in;
         inflight_ff <= inflight_in;
         out_occ_ff  <= out_occ_in;
         if (inflight_ff) begin
            out_wr_ff <= ~out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= ~out_rd_ff;
         end
      end
   end

   // window memory, read before write on the same edge
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
         rd_cur_ff  <= q_item.blk;
         rd_last_ff <= last_rd;
      end
      if (wr_en) begin
         mem[wr_addr] <= q_item.blk;
      end
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (inflight_ff) begin
         out_ff[out_wr_ff] <= '{earlier: rd_data_ff, current: rd_cur_ff, last: rd_last_ff};
      end
   end

endmodule

// ----- tb/tb_sliding_window_block_pair_emitter.sv -----
module tb_sliding_window_block_pair_emitter;
   import swbpe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN_DEPTH        = 16;
   localparam int RANDOM_ITEMS     = 390;
   localparam int SETTLE_CYCLES    = 8;
   localparam int END_CYCLES       = 24;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT       = 4000;
   localparam int PRESSURE_PHASE   = 2;
   localparam int MAX_REPORTS      = 10;
   localparam logic [BLK_W-1:0] REP_STRIDE = 64'h0123_4567_89AB_CDEF;
   localparam logic [BLK_W-1:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_ACCESS,
      ROW_TYPED
   } row_kind_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // one directed step: a register write, a run of accesses, or an access with its pair typed in
   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] data;
      logic [BLK_W-1:0]     offset;
      logic [4:0]           reps;
      logic                 exp_pair;
      logic [BLK_W-1:0]     exp_earlier;
      logic [BLK_W-1:0]     exp_current;
   } dir_row_type;

   typedef struct packed {
      logic [BLK_W-1:0] earlier;
      logic [BLK_W-1:0] current;
      logic             last;
   } block_pair_type;

   localparam int DIR_ROWS = 16;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // window size zero after reset: nothing comes out
      '{ROW_TYPED,  CSR_WINDOW_SIZE, 6'd0,  64'h0000_0000_0001_0000, 5'd1, 1'b0, 64'd0, 64'd0},
      '{ROW_CSR,    CSR_WINDOW_SIZE, 6'd1,  64'd0, 5'd0, 1'b0, 64'd0, 64'd0},
      // empty window, then a single entry
      '{ROW_TYPED,  CSR_WINDOW_SIZE, 6'd0,  ALL_ONES, 5'd1, 1'b0, 64'd0, 64'd0},
      '{ROW_TYPED,  CSR_WINDOW_SIZE, 6'd0,  64'd0, 5'd1, 1'b1,
        64'h0000_FFFF_FFFF_FFFF, 64'd0},
      '{ROW_CSR,    CSR_BLOCK_SHIFT, 6'd0,  64'd0, 5'd0, 1'b0, 64'd0, 64'd0},
      '{ROW_TYPED,  CSR_WINDOW_SIZE, 6'd0,  ALL_ONES, 5'd1, 1'b1, 64'd0, ALL_ONES},
      '{ROW_CSR,    CSR_BLOCK_SHIFT, 6'd63, 64'd0, 5'd0, 1'b0, 64'd0, 64'd0},
      '{ROW_TYPED,  CSR_WINDOW_SIZE, 6'd0,  64'h8000_0000_0000_0000, 5'd1, 1'b1,
        ALL_ONES, 64'd1},
      '{ROW_TYPED,  CSR_WINDOW_SIZE, 6'd0,  64'h7FFF_FFFF_FFFF_FFFF, 5'd1, 1'b1,
        64'd1, 64'd0},
      // window size above depth saturates, top data bit is dropped
      '{ROW_CSR,    CSR_WINDOW_SIZE, 6'h3F, 64'd0, 5'd0, 1'b0, 64'd0, 64'd0},
      '{ROW_CSR,    CSR_BLOCK_SHIFT, 6'd4,  64'd0, 5'd0, 1'b0, 64'd0, 64'd0},
      '{ROW_ACCESS, CSR_WINDOW_SIZE, 6'd0,  64'h0000_0000_0000_0100, 5'd17, 1'b0, 64'd0, 64'd0},
      // lowered while full: the window stops growing and keeps its entries
      '{ROW_CSR,    CSR_WINDOW_SIZE, 6'd2,  64'd0, 5'd0, 1'b0, 64'd0, 64'd0},
      '{ROW_ACCESS, CSR_WINDOW_SIZE, 6'd0,  64'hDEAD_BEEF_0000_0000, 5'd2, 1'b0, 64'd0, 64'd0},
      '{ROW_CSR,    CSR_WINDOW_SIZE, 6'd0,  64'd0, 5'd0, 1'b0, 64'd0, 64'd0},
      '{ROW_ACCESS, CSR_WINDOW_SIZE, 6'd0,  64'h5555_5555_5555_5555, 5'd1, 1'b0, 64'd0, 64'd0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WINDOW_SIZE;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BLK_W-1:0]     req_byte_offset = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BLK_W-1:0]     rsp_earlier_block;
   logic [BLK_W-1:0]     rsp_current_block;
   logic                 rsp_last_pair;

   sliding_window_block_pair_emitter #(
      .WINDOW_DEPTH(WIN_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_offset  (req_byte_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_earlier_block(rsp_earlier_block),
      .rsp_current_block(rsp_current_block),
      .rsp_last_pair    (rsp_last_pair)
   );

   // window model and its registers
   logic [BLK_W-1:0]   win_hist [WIN_DEPTH];
   int                 win_fill = 0;
   logic [SIZE_W-1:0]  win_size = '0;
   logic [SHIFT_W-1:0] blk_shift = BLOCK_SHIFT_RESET;

   block_pair_type expected_pairs [$];
   int             error_count = 0;

   // sender state
   bit valid_up = 1'b0;
   int burst_left = 0;
   bit no_idle = 1'b0;

   // receiver hold-off requests, served in the receiver process
   int hold_requests = 0;
   int holds_done = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void log_failure(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%s", msg);
   endfunction

   // pairs one access with the window, most recent first, then pushes its block
   function automatic void predict_pairs(input logic [BLK_W-1:0] offset, input bit emit);
      logic [BLK_W-1:0] blk;
      int limit;
      int n;
      int fill;
      blk = offset >> blk_shift;
      limit = (win_size > WIN_DEPTH) ? WIN_DEPTH : int'(win_size);
      n = win_fill;
      if (emit)
         for (int k = 0; k < n; k++)
            expected_pairs.push_back('{win_hist[k], blk, (k + 1 == n)});
      fill = n + 1;
      if (fill > limit)
         fill--;
      for (int k = fill - 1; k > 0; k--)
         win_hist[k] = win_hist[k - 1];
      if (fill > 0)
         win_hist[0] = blk;
      win_fill = fill;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_WINDOW_SIZE)
         win_size = data[SIZE_W-1:0];
      else
         blk_shift = data[SHIFT_W-1:0];
      @(posedge clock);
   endtask

   // drop valid, let every pending pair come out, then give the block time to settle
   task automatic wait_drained();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
      while (expected_pairs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // offer one beat, with a random gap whenever the current burst is used up
   task automatic send_access(input logic [BLK_W-1:0] offset);
      if (burst_left == 0) begin
         if (valid_up) begin
            req_valid <= 1'b0;
            valid_up = 1'b0;
         end
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = no_idle ? (1 << 20) : $urandom_range(1, 12);
      end
      req_valid       <= 1'b1;
      req_byte_offset <= offset;
      valid_up = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      burst_left--;
   endtask

   // receiver stall pattern, with a long hold-off when asked
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             hold_left = 0;
   int unsigned    stall_tick = 0;

   always @(posedge clock) begin
      stall_tick++;
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holds_done != hold_requests) begin
         holds_done++;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_stall <= (stall_tick % 5 < 2);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      block_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pairs.size() == 0) begin
            log_failure($sformatf("unexpected pair earlier=%h current=%h last=%b",
                                  rsp_earlier_block, rsp_current_block, rsp_last_pair));
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_earlier_block !== want.earlier || rsp_current_block !== want.current ||
                rsp_last_pair !== want.last)
               log_failure($sformatf(
                  "pair mismatch: expected %h/%h/%b, got %h/%h/%b",
                  want.earlier, want.current, want.last,
                  rsp_earlier_block, rsp_current_block, rsp_last_pair));
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [BLK_W-1:0]     offset;
      logic [BLK_W-1:0]     prev_offset;
      logic [CSR_DAT_W-1:0] size_data;
      logic [CSR_DAT_W-1:0] shift_data;
      int                   random_sent;
      int                   phase;
      int                   run_len;
      dir_row_type          row;

      random_sent = 0;
      phase = 0;
      prev_offset = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         row = DIR_TABLE[r];
         if (row.kind == ROW_CSR) begin
            wait_drained();
            csr_write(row.idx, row.data);
         end else begin
            for (int k = 0; k < row.reps; k++) begin
               offset = row.offset + REP_STRIDE * k;
               send_access(offset);
               if (row.kind == ROW_TYPED) begin
                  predict_pairs(offset, 1'b0);
                  if (row.exp_pair)
                     expected_pairs.push_back('{row.exp_earlier, row.exp_current, 1'b1});
               end else begin
                  predict_pairs(offset, 1'b1);
               end
            end
         end
      end

      // random phases, each with its own window size and often a new block shift
      while (random_sent < RANDOM_ITEMS) begin
         wait_drained();
         case ($urandom_range(0, 7))
            0:       size_data = 6'd0;
            1:       size_data = 6'd1;
            2:       size_data = 6'd16;
            3:       size_data = 6'd31;
            4:       size_data = 6'd17;
            5:       size_data = 6'h20;
            default: size_data = 6'($urandom_range(0, 63));
         endcase
         case ($urandom_range(0, 5))
            0:       shift_data = 6'd0;
            1:       shift_data = 6'd63;
            2:       shift_data = BLOCK_SHIFT_RESET;
            default: shift_data = 6'($urandom_range(0, 63));
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         if (phase == PRESSURE_PHASE) begin
            size_data = 6'd16;
            no_idle = 1'b1;
         end
         csr_write(CSR_WINDOW_SIZE, size_data);
         if (phase == PRESSURE_PHASE || $urandom_range(0, 3) != 0)
            csr_write(CSR_BLOCK_SHIFT, shift_data);
         burst_left = 0;
         // long receiver hold-off while beats keep coming
         if (phase == PRESSURE_PHASE)
            hold_requests++;
         run_len = (phase == PRESSURE_PHASE) ? 40 : $urandom_range(8, 40);
         repeat (run_len) begin
            case ($urandom_range(0, 7))
               0:       offset = ALL_ONES;
               1:       offset = '0;
               2:       offset = {32'd0, 32'($urandom)};
               3:       offset = prev_offset;
               default: offset = {32'($urandom), 32'($urandom)};
            endcase
            send_access(offset);
            predict_pairs(offset, 1'b1);
            prev_offset = offset;
            random_sent++;
         end
         phase++;
      end

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_pairs.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- sliding_window_block_pair_emitter.f -----
rtl/core/swbpe_pkg.sv
rtl/core/swbpe_queue.sv
rtl/core/swbpe_front.sv
rtl/core/swbpe_back.sv
rtl/core/sliding_window_block_pair_emitter.sv
tb/tb_sliding_window_block_pair_emitter.sv
